### hdl/raft_leader_replication_tracker_top_macros.svh
// Assertion macros for the replication tracker top level.
// Included by the top level only.
`ifndef RAFT_LEADER_REPLICATION_TRACKER_TOP_MACROS_SVH
`define RAFT_LEADER_REPLICATION_TRACKER_TOP_MACROS_SVH
`define RLRT_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define RLRT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### hdl/rlrt_pkg.sv
// Shared types and constants for the replication tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rlrt_pkg;
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_REPLY  = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;
    localparam logic [1:0] OP_REQ    = 2'd3;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_START  = 7'b0000100,
        ST_REPLY  = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_EVAL   = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load;
        logic do_start;
        logic start_slot;
        logic do_reply;
        logic do_request;
        logic scan_clear;
        logic scan_step;
        logic commit_adv;
        logic commit_done;
        logic emit;
        logic emit_send;
        logic emit_last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       slot_end;
        logic       scan_end;
        logic       commit_go;
        logic       reply_send;
    } status_t;
endpackage
`default_nettype wire

### hdl/raft_leader_replication_tracker_top.sv
// Top level of the Raft leader replication tracker.
// Depends on rlrt_pkg, rlrt_ctrl, rlrt_datapath and the macros header.
//
// channel   | handshake            | payload
// request   | start / busy         | operation .. initial_commit
// result    | strobe (send_valid)  | send_* .. last
// config    | cfg_valid/cfg_ready  | cfg_data (active_followers)
//
// Start emits one result per cycle, one for each active follower (a single
// result with no follower). Commit repeats the serial match-table scan for
// each candidate index it checks. Reset is asynchronous; tables reset to -1/0.
// Results cannot be stalled; busy holds off new requests.
`timescale 1ns / 1ps
`default_nettype none
`include "raft_leader_replication_tracker_top_macros.svh"
module raft_leader_replication_tracker_top #(
    parameter int FOLLOWERS  = 8,
    parameter int INDEX_BITS = 16,
    parameter int TERM_BITS  = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [3:0]                 cfg_data,
    input  wire logic [1:0]                 operation,
    input  wire logic [2:0]                 follower_id,
    input  wire logic [TERM_BITS-1:0]       peer_term,
    input  wire logic                       reply_success,
    input  wire logic                       request_is_vote,
    input  wire logic [INDEX_BITS-1:0]      log_length,
    input  wire logic signed [INDEX_BITS:0] initial_commit,
    output logic                            strobe,
    output logic                            send_valid,
    output logic [2:0]                      send_follower,
    output logic signed [INDEX_BITS:0]      send_start,
    output logic signed [INDEX_BITS:0]      send_end,
    output logic                            step_down,
    output logic [TERM_BITS-1:0]            term_out,
    output logic                            granted,
    output logic signed [INDEX_BITS:0]      commit_out,
    output logic                            last
);
    import rlrt_pkg::*;

    cmd_t    cmd;
    status_t stat;
    logic [3:0] act_reg;
    logic       res_reg, sv_raw;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            act_reg <= 4'd4;
        else if (cfg_valid && cfg_ready)
            act_reg <= cfg_data;
    end

    rlrt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    rlrt_datapath #(
        .FOLLOWERS  (FOLLOWERS),
        .INDEX_BITS (INDEX_BITS),
        .TERM_BITS  (TERM_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .active_followers (act_reg),
        .operation        (operation),
        .follower_id      (follower_id),
        .peer_term        (peer_term),
        .reply_success    (reply_success),
        .request_is_vote  (request_is_vote),
        .log_length       (log_length),
        .initial_commit   (initial_commit),
        .send_valid       (res_reg),
        .send_follower    (send_follower),
        .send_start       (send_start),
        .send_end         (send_end),
        .step_down        (step_down),
        .term_out         (term_out),
        .granted          (granted),
        .commit_out       (commit_out),
        .last             (last)
    );

    logic sv_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg <= 1'b0;
        else
            sv_reg <= cmd.emit_send;
    end
    assign sv_raw = res_reg;
    assign strobe = sv_raw;
    assign send_valid = sv_raw & sv_reg;

    `RLRT_ASSERT_IMPL(a_last_strobe, clk, rst_n, last, strobe)
    `RLRT_ASSERT_IMPL(a_valid_strobe, clk, rst_n, send_valid, strobe)
    `RLRT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
endmodule
`default_nettype wire

### hdl/rlrt_ctrl.sv
// Controller state machine for the replication tracker.
// Depends on rlrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rlrt_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire rlrt_pkg::status_t stat,
    output rlrt_pkg::cmd_t        cmd
);
    import rlrt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.op)
                    OP_START:
                    begin
                        cmd.do_start = 1'b1;
                        state_next = ST_START;
                    end
                    OP_REPLY:
                    begin
                        state_next = ST_REPLY;
                    end
                    OP_COMMIT:
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next = ST_SCAN;
                    end
                    default:
                    begin
                        cmd.do_request = 1'b1;
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_START:
            begin
                // scan_end marks the final active slot, or slot 0 with none
                cmd.start_slot = 1'b1;
                cmd.emit = 1'b1;
                cmd.emit_send = ~stat.slot_end;
                cmd.emit_last = stat.scan_end;
                if (stat.scan_end)
                    state_next = ST_IDLE;
            end
            ST_REPLY:
            begin
                cmd.do_reply = 1'b1;
                state_next = ST_EMIT;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_end)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (stat.commit_go)
                begin
                    cmd.commit_adv = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    cmd.commit_done = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                cmd.emit_send = stat.reply_send;
                cmd.emit_last = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### hdl/rlrt_datapath.sv
// Datapath of the replication tracker: follower tables, term, commit.
// Depends on rlrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rlrt_datapath #(
    parameter int FOLLOWERS  = 8,
    parameter int INDEX_BITS = 16,
    parameter int TERM_BITS  = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire rlrt_pkg::cmd_t          cmd,
    output rlrt_pkg::status_t            stat,
    input  wire logic [3:0]              active_followers,
    input  wire logic [1:0]              operation,
    input  wire logic [2:0]              follower_id,
    input  wire logic [TERM_BITS-1:0]    peer_term,
    input  wire logic                    reply_success,
    input  wire logic                    request_is_vote,
    input  wire logic [INDEX_BITS-1:0]   log_length,
    input  wire logic signed [INDEX_BITS:0] initial_commit,
    output logic                         send_valid,
    output logic [2:0]                   send_follower,
    output logic signed [INDEX_BITS:0]   send_start,
    output logic signed [INDEX_BITS:0]   send_end,
    output logic                         step_down,
    output logic [TERM_BITS-1:0]         term_out,
    output logic                         granted,
    output logic signed [INDEX_BITS:0]   commit_out,
    output logic                         last
);
    import rlrt_pkg::*;

    localparam int IW = INDEX_BITS + 1;
    localparam int SW = (FOLLOWERS > 1) ? $clog2(FOLLOWERS) : 1;
    localparam int CW = $clog2(FOLLOWERS + 1);
    localparam logic signed [IW:0] MINUS1 = -1;

    logic signed [IW-1:0] next_reg [FOLLOWERS];
    logic signed [IW-1:0] match_reg [FOLLOWERS];
    logic signed [IW-1:0] prev_reg [FOLLOWERS];
    logic signed [IW-1:0] cnt_reg [FOLLOWERS];
    logic [TERM_BITS-1:0] term_reg;
    logic signed [IW-1:0] commit_reg;
    logic                 down_reg;

    logic [1:0]            op_reg;
    logic [2:0]            fid_reg;
    logic [TERM_BITS-1:0]  pt_reg;
    logic                  succ_reg, vote_reg, granted_reg, rsend_reg;
    logic signed [IW:0]    len_reg;
    logic signed [IW-1:0]  ic_reg;
    logic [CW-1:0]         act_reg, slot_reg, hits_reg;
    logic signed [IW:0]    c_reg;
    logic signed [IW:0]    rs_reg, re_reg;
    logic [2:0]            rf_reg;

    logic [CW-1:0] act_in;
    assign act_in = (active_followers > 4'(FOLLOWERS)) ? CW'(FOLLOWERS)
                                                       : CW'(active_followers);

    logic [SW-1:0] slot_ix, fid_ix;
    assign slot_ix = slot_reg[SW-1:0];
    assign fid_ix  = SW'(fid_reg);

    logic fid_act;
    assign fid_act = ({1'b0, fid_reg} < 4'(act_reg));

    // send-range check: start >= 0, start <= end, end < len
    function automatic logic range_ok(input logic signed [IW:0] s,
                                      input logic signed [IW:0] e,
                                      input logic signed [IW:0] l);
        range_ok = (s >= 0) && (s <= e) && (e < l);
    endfunction

    logic signed [IW:0] lm1, snx, smt, sum_r, dec_r, ic_sat;
    assign lm1   = len_reg - 1;
    assign snx   = (IW+1)'(next_reg[fid_ix]);
    assign sum_r = (IW+1)'(prev_reg[fid_ix]) + (IW+1)'(cnt_reg[fid_ix]);
    assign smt   = (cnt_reg[fid_ix] != 0) ? sum_r + 1 : snx;
    assign dec_r = snx - 1;

    always_comb
    begin
        ic_sat = (IW+1)'(initial_commit);
        if (ic_sat < MINUS1)
            ic_sat = MINUS1;
        if (ic_sat > (IW+1)'((1 << INDEX_BITS) - 2))
            ic_sat = (IW+1)'((1 << INDEX_BITS) - 2);
    end

    logic signed [IW:0] match_s;
    assign match_s = (IW+1)'(match_reg[slot_ix]);

    assign stat.op         = op_reg;
    assign stat.slot_end   = (slot_reg >= act_reg);
    assign stat.scan_end   = (slot_reg + 1'b1 >= act_reg) || (act_reg == 0);
    assign stat.commit_go  = (c_reg < len_reg) &&
                             ((CW+1)'(hits_reg) + 1 > (CW+1)'(act_reg >> 1));
    assign stat.reply_send = rsend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FOLLOWERS; i++)
            begin
                next_reg[i]  <= '1;
                match_reg[i] <= '1;
                prev_reg[i]  <= '1;
                cnt_reg[i]   <= '0;
            end
            term_reg    <= '0;
            commit_reg  <= '1;
            down_reg    <= 1'b0;
            send_valid  <= 1'b0;
            last        <= 1'b0;
            granted_reg <= 1'b0;
            rsend_reg   <= 1'b0;
        end
        else
        begin
            send_valid <= cmd.emit;
            last       <= cmd.emit & cmd.emit_last;
            if (cmd.load)
            begin
                granted_reg <= 1'b0;
                rsend_reg   <= 1'b0;
            end
            if (cmd.do_start)
            begin
                term_reg   <= pt_reg;
                commit_reg <= ic_reg;
                down_reg   <= 1'b0;
            end
            if (cmd.start_slot && !stat.slot_end)
            begin
                next_reg[slot_ix]  <= IW'(lm1);
                match_reg[slot_ix] <= '1;
                if (range_ok(lm1, lm1, len_reg))
                begin
                    prev_reg[slot_ix] <= IW'(lm1 - 1);
                    cnt_reg[slot_ix]  <= IW'(1);
                end
                else
                begin
                    prev_reg[slot_ix] <= '1;
                    cnt_reg[slot_ix]  <= '0;
                end
            end
            if (cmd.do_reply && !down_reg && fid_act)
            begin
                if (pt_reg > term_reg)
                begin
                    term_reg <= pt_reg;
                    down_reg <= 1'b1;
                end
                else if (succ_reg || snx >= 0)
                begin
                    logic signed [IW:0] ns, s, e;
                    ns = succ_reg ? smt : dec_r;
                    if (succ_reg && cnt_reg[fid_ix] != 0)
                    begin
                        next_reg[fid_ix]  <= IW'(ns);
                        match_reg[fid_ix] <= IW'(sum_r);
                    end
                    else if (!succ_reg)
                        next_reg[fid_ix] <= IW'(ns);
                    if (succ_reg && (ns >= len_reg || len_reg == 0))
                    begin
                        s = MINUS1;
                        e = MINUS1;
                    end
                    else
                    begin
                        s = ns;
                        e = lm1;
                    end
                    rsend_reg <= 1'b1;
                    if (range_ok(s, e, len_reg))
                    begin
                        prev_reg[fid_ix] <= IW'(s - 1);
                        cnt_reg[fid_ix]  <= IW'(e - s + 1);
                    end
                    else
                    begin
                        prev_reg[fid_ix] <= '1;
                        cnt_reg[fid_ix]  <= '0;
                    end
                end
            end
            if (cmd.do_request)
            begin
                if (vote_reg ? (pt_reg > term_reg) : (pt_reg >= term_reg))
                begin
                    term_reg    <= pt_reg;
                    down_reg    <= 1'b1;
                    granted_reg <= 1'b1;
                end
            end
            if (cmd.commit_done && !down_reg)
                commit_reg <= IW'((c_reg >= len_reg) ? lm1 : c_reg);
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        logic signed [IW:0] s, e, ns;
        if (cmd.load)
        begin
            op_reg   <= operation;
            fid_reg  <= follower_id;
            pt_reg   <= peer_term;
            succ_reg <= reply_success;
            vote_reg <= request_is_vote;
            len_reg  <= (IW+1)'(log_length);
            ic_reg   <= IW'(ic_sat);
            act_reg  <= act_in;
        end
        if (cmd.do_start)
            slot_reg <= '0;
        if (cmd.start_slot && !stat.slot_end)
            slot_reg <= slot_reg + 1'b1;
        if (cmd.scan_clear)
        begin
            slot_reg <= '0;
            hits_reg <= '0;
            if (!cmd.commit_adv)
                c_reg <= (IW+1)'(commit_reg);
        end
        if (cmd.commit_adv)
            c_reg <= c_reg + 1;
        if (cmd.scan_step)
        begin
            if (act_reg != 0 && match_s >= c_reg + 1)
                hits_reg <= hits_reg + 1'b1;
            slot_reg <= slot_reg + 1'b1;
        end
        if (cmd.do_reply)
        begin
            ns = succ_reg ? smt : dec_r;
            if (succ_reg && (ns >= len_reg || len_reg == 0))
            begin
                s = MINUS1;
                e = MINUS1;
            end
            else
            begin
                s = ns;
                e = lm1;
            end
            if (!range_ok(s, e, len_reg))
            begin
                s = MINUS1;
                e = MINUS1;
            end
            rs_reg <= s;
            re_reg <= e;
            rf_reg <= fid_reg;
        end
        if (cmd.emit)
        begin
            if (cmd.emit_send && cmd.start_slot)
            begin
                send_follower <= 3'(slot_reg);
                send_start <= range_ok(lm1, lm1, len_reg) ? IW'(lm1) : '1;
                send_end   <= range_ok(lm1, lm1, len_reg) ? IW'(lm1) : '1;
            end
            else if (cmd.emit_send)
            begin
                send_follower <= rf_reg;
                send_start    <= IW'(rs_reg);
                send_end      <= IW'(re_reg);
            end
            else
            begin
                send_follower <= '0;
                send_start    <= '1;
                send_end      <= '1;
            end
        end
    end

    assign step_down  = down_reg;
    assign term_out   = term_reg;
    assign granted    = granted_reg;
    assign commit_out = commit_reg;
endmodule
`default_nettype wire
